// ----- src/dq_pkg.sv -----
// Shared types and constants for the double-ended queue.
package dq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CMD_W         = 3;
   localparam int WORD_W        = 32;
   localparam int STATUS_W      = 2;
   localparam int OCC_W         = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR      = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_LIST       = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LIST
   } state_type;

endpackage

// ----- src/dq_ram.sv -----
// Ring store of queue elements: one write port, one registered read port.
module dq_ram import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [WORD_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [WORD_W-1:0] rd_data
);

   logic signed [WORD_W-1:0] slots_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/dq_ctrl.sv -----
// Command sequencer: ring pointers, element count and the result register.
module dq_ctrl import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [WORD_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_item,
   output logic                       rsp_last,
   output logic [OCC_W-1:0]           rsp_occupancy,
   output logic                       wr_en,
   output logic [IDX_W-1:0]           wr_addr,
   output logic signed [WORD_W-1:0]   wr_data,
   output logic                       rd_en,
   output logic [IDX_W-1:0]           rd_addr,
   input  logic signed [WORD_W-1:0]   rd_data
);

   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         list_idx_ff, list_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      status_ff, status_in;
   logic signed [WORD_W-1:0] item_ff, item_in;
   logic                     last_ff, last_in;
   logic [OCC_W-1:0]         occ_ff, occ_in;

   logic             out_free;
   logic             load;
   logic             full;
   logic             empty;
   logic             list_last;
   logic [CNT_W-1:0] count_m1;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign count_m1  = count_ff - CNT_W'(1);
   assign list_last = ((list_idx_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      list_idx_in = list_idx_ff;
      req_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = front_ff;
      wr_data     = req_value;
      rd_en       = 1'b0;
      rd_addr     = front_ff;
      load        = 1'b0;
      status_in   = STAT_OK;
      item_in     = '0;
      last_in     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     front_in = '0;
                     count_in = '0;
                     load     = 1'b1;
                  end
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     load = 1'b1;
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                        if (req_cmd == CMD_PUSH_FRONT) begin
                           front_in = ring_add(front_ff, IDX_W'(DEPTH - 1));
                           wr_addr  = front_in;
                        end else begin
                           wr_addr = ring_add(front_ff, count_ff[IDX_W-1:0]);
                        end
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (empty) begin
                        load      = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_m1;
                        state_in = ST_READ;
                        if (req_cmd == CMD_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = ring_add(front_ff, IDX_W'(1));
                        end else begin
                           rd_addr = ring_add(front_ff, count_m1[IDX_W-1:0]);
                        end
                     end
                  end
                  CMD_LIST: begin
                     if (empty) begin
                        load      = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = front_ff;
                        rd_ptr_in   = ring_add(front_ff, IDX_W'(1));
                        list_idx_in = '0;
                        state_in    = ST_LIST;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               load     = 1'b1;
               item_in  = rd_data;
               state_in = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (out_free) begin
               load    = 1'b1;
               item_in = rd_data;
               last_in = list_last;
               if (list_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = rd_ptr_ff;
                  rd_ptr_in   = ring_add(rd_ptr_ff, IDX_W'(1));
                  list_idx_in = list_idx_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      occ_in       = OCC_W'(count_in);
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      list_idx_ff <= list_idx_in;
      if (load) begin
         status_ff <= status_in;
         item_ff   <= item_in;
         last_ff   <= last_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_item      = item_ff;
   assign rsp_last      = last_ff;
   assign rsp_occupancy = occ_ff;

endmodule

// ----- src/double_ended_queue.sv -----
// Top level of the bounded double-ended queue.
//
// A bounded double-ended queue of up to DEPTH signed 32-bit elements, held in a
// single-port-write, registered-read ring memory addressed by a front index and
// an element count. Each request beat carries a command (clear, push front, push
// back, pop front, pop back, list) and a value; every request yields one or more
// response beats with status, item, last flag and the occupancy after the
// command. Clear, push and any empty or full report are answered from the idle
// state. A pop that returns data reads the memory on accept and then loads the
// registered read data from the read state. A list returns one element per
// cycle after the first read while the response register is free or being
// drained, and holds off new requests until its last beat is loaded. A push
// into a full queue is dropped with a full status; a pop or list on an empty
// queue returns a single empty beat. When idle, a new request is taken as soon
// as the response register is free or being drained. No clearing pass is needed
// after reset: the queue starts empty and only held elements are ever read.
module double_ended_queue import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_item,
   output logic                     rsp_last,
   output logic [OCC_W-1:0]         rsp_occupancy
);

   localparam int IDX_W = $clog2(DEPTH);

   // memory port between the sequencer and the ring store
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [WORD_W-1:0] wr_data;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [WORD_W-1:0] rd_data;

   // sequencer: decode the command, advance the pointers, own the response beat
   dq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_item      (rsp_item),
      .rsp_last      (rsp_last),
      .rsp_occupancy (rsp_occupancy),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   // ring store: writes come only from pushes, reads only from pops and list,
   // and the sequencer never issues both in one cycle, so no forwarding is needed
   dq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- src/dq_checker.sv -----
// Port-level assertions for the double-ended queue, bound to the top level.
module dq_checker import dq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [WORD_W-1:0] rsp_item,
   input logic                     rsp_last,
   input logic [OCC_W-1:0]         rsp_occupancy
);

   // hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_item)
         && $stable(rsp_last) && $stable(rsp_occupancy))
      else $error("stalled response beat changed");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_occupancy == '0)
      else $error("empty report with nonzero occupancy");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_occupancy == OCC_W'(DEPTH))
      else $error("full report below capacity");

   a_report_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_item == '0 && rsp_last)
      else $error("empty or full report carries data or is not last");

   // a list in flight blocks new requests until its last beat
   a_list_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken during a list");

endmodule

bind double_ended_queue dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
